@@ src/pcrt_pkg.sv @@
// types, constants and helper functions for the poisson coverage ratio test unit
// no dependencies; used by every other file in src except pcrt_delay
package pcrt_pkg;

    localparam int CA_W   = 32;
    localparam int LEN_W  = 24;
    localparam int RL_W   = 16;
    localparam int TOL_W  = 15;
    localparam int K_W    = 17;
    localparam int PROD_W = 56;
    localparam int P_W    = 57;
    localparam int Q_W    = 42;
    localparam int CMP_W  = 49;
    localparam int LG_W   = 23;
    localparam int DL_W   = 26;
    localparam int FRAC_W = 16;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO_TOL   = 1'b1;

    localparam logic [RL_W-1:0]  RL_RESET  = 16'd100;
    localparam logic [TOL_W-1:0] TOL_RESET = 15'd3277;
    localparam logic [K_W-1:0]   ONE_Q16   = 17'd65536;
    localparam logic [29:0]      LN2_Q30   = 30'd744261118;

    // quotient bits resolved per divider stage
    localparam int DIV_STEPS = 4;
    localparam int DIV_LAT   = (PROD_W + DIV_STEPS - 1) / DIV_STEPS;
    localparam int LOG_LAT   = 4;
    localparam int TERM_LAT  = 4;

    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        logic [CA_W-1:0]  coverage_a;
        logic [CA_W-1:0]  coverage_b;
        logic [LEN_W-1:0] length_a;
        logic [LEN_W-1:0] length_b;
    } t_in;

    typedef struct packed {
        logic signed [63:0] log_ratio;
        logic               status;
    } t_out;

    // log2(1 + i/2^tb) in Q16 by repeated truncating squaring, last entry 1.0
    function automatic logic [16:0] lg_tab_entry(input int unsigned i, input int unsigned tb);
        logic [63:0] v;
        logic [16:0] r;
        int          k;
        if (i >= (32'd1 << tb)) begin
            return 17'd65536;
        end
        v = (64'd1 << 30) + (64'(i) << (30 - tb));
        r = '0;
        for (k = 1; k <= 16; k++) begin
            v = (v * v) >> 30;
            if (v >= (64'd1 << 31)) begin
                v = v >> 1;
                r = r | (17'd1 << (16 - k));
            end
        end
        return r;
    endfunction

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? S64_MIN : S64_MAX;
        end
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? S64_MIN : S64_MAX;
        end
        return s[63:0];
    endfunction

endpackage

@@ src/pcrt_delay.sv @@
// enabled shift line that keeps words aligned across the pipeline
// depends on nothing
module pcrt_delay #(
    parameter int W = 8,
    parameter int D = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_sh [D];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < D; i++) r_sh[i] <= '0;
        end else if (i_en) begin
            r_sh[0] <= i_d;
            for (int i = 1; i < D; i++) r_sh[i] <= r_sh[i-1];
        end
    end

    assign o_q = r_sh[D-1];

endmodule

@@ src/pcrt_log2.sv @@
// four stage log2 unit: msb search, normalise, table plus interpolation, assemble
// depends on pcrt_pkg
module pcrt_log2 #(
    parameter int W  = 57,
    parameter int TB = 8
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [W-1:0]               i_x,
    output logic [pcrt_pkg::LG_W-1:0]  o_lg
);

    localparam int TAB_N = 1 << TB;

    logic [16:0] tab [0:TAB_N];

    for (genvar g = 0; g <= TAB_N; g++) begin : g_tab
        assign tab[g] = pcrt_pkg::lg_tab_entry(g, TB);
    end

    logic [5:0]    n1;
    logic [W-1:0]  r_x;
    logic [5:0]    r_n1, r_n2, r_n3;
    logic          r_z1, r_z2, r_z3;
    logic [63:0]   m;
    logic [TB-1:0] r_idx;
    logic [15:0]   r_r;
    logic [16:0]   t0, t1, diff, frac;
    logic [32:0]   prod;
    logic [16:0]   r_frac;
    logic [pcrt_pkg::LG_W-1:0] r_lg;

    always_comb begin
        n1 = '0;
        for (int i = 0; i < W; i++) begin
            if (i_x[i]) n1 = 6'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x  <= i_x;
            r_n1 <= n1;
            r_z1 <= (i_x == '0);
        end
    end

    // bring the top set bit to position 63
    assign m = 64'(r_x) << (6'd63 - r_n1);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_idx <= m[62 -: TB];
            r_r   <= m[62-TB -: 16];
            r_n2  <= r_n1;
            r_z2  <= r_z1;
        end
    end

    always_comb begin
        t0   = tab[{1'b0, r_idx}];
        t1   = tab[(TB+1)'({1'b0, r_idx}) + (TB+1)'(1)];
        diff = t1 - t0;
        prod = 33'(diff) * 33'(r_r);
        frac = t0;
        if (t1 > t0) frac = t0 + prod[32:16];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_frac <= frac;
            r_n3   <= r_n2;
            r_z3   <= r_z2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lg <= r_z3 ? '0 : pcrt_pkg::LG_W'({r_n3, 16'h0000})
                               + pcrt_pkg::LG_W'(r_frac);
        end
    end

    assign o_lg = r_lg;

endmodule

@@ src/pcrt_div.sv @@
// pipelined restoring divider, a few quotient bits per stage
// depends on pcrt_pkg
module pcrt_div (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [pcrt_pkg::PROD_W-1:0]  i_num,
    input  logic [pcrt_pkg::RL_W-1:0]    i_den,
    output logic [pcrt_pkg::PROD_W-1:0]  o_quo
);

    localparam int NP  = pcrt_pkg::DIV_LAT * pcrt_pkg::DIV_STEPS;
    localparam int DW  = pcrt_pkg::RL_W;
    localparam int LAT = pcrt_pkg::DIV_LAT;

    for (genvar s = 0; s < LAT; s++) begin : g_st
        logic [NP-1:0] q_in, q_c, r_q;
        logic [DW-1:0] rem_in, rem_c, den_in, r_rem, r_den;
        logic [DW:0]   t;

        if (s == 0) begin : g_first
            assign q_in   = NP'(i_num);
            assign rem_in = '0;
            assign den_in = i_den;
        end else begin : g_next
            assign q_in   = g_st[s-1].r_q;
            assign rem_in = g_st[s-1].r_rem;
            assign den_in = g_st[s-1].r_den;
        end

        // numerator bits shift out of the top, quotient bits shift in below
        always_comb begin
            q_c   = q_in;
            rem_c = rem_in;
            t     = '0;
            for (int j = 0; j < pcrt_pkg::DIV_STEPS; j++) begin
                t   = {rem_c, q_c[NP-1]};
                q_c = {q_c[NP-2:0], 1'b0};
                if (t >= {1'b0, den_in}) begin
                    t      = t - {1'b0, den_in};
                    q_c[0] = 1'b1;
                end
                rem_c = t[DW-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q   <= q_c;
                r_rem <= rem_c;
                r_den <= den_in;
            end
        end
    end

    assign o_quo = g_st[LAT-1].r_q[pcrt_pkg::PROD_W-1:0];

endmodule

@@ src/pcrt_term.sv @@
// one likelihood term: ln2 scaling, split wide product, saturate and sign
// depends on pcrt_pkg
module pcrt_term (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [pcrt_pkg::PROD_W-1:0]       i_yq,
    input  logic signed [pcrt_pkg::DL_W-1:0]  i_dl,
    output logic signed [63:0]                o_val
);

    localparam int DW = pcrt_pkg::DL_W;
    localparam int HW = pcrt_pkg::PROD_W / 2;
    localparam int PW = HW + DW;
    localparam int FW = 2 * HW + DW;

    logic [DW-1:0]      mag;
    logic [DW+29:0]     r_ln;
    logic               r_neg1, r_neg2, r_neg3;
    logic [pcrt_pkg::PROD_W-1:0] r_yq;
    logic [DW+30:0]     ln_rnd;
    logic [DW-1:0]      lnm;
    logic [PW-1:0]      r_pl, r_ph;
    logic [FW-1:0]      r_prod;
    logic signed [63:0] mag64;
    logic signed [63:0] r_val;

    assign mag = i_dl[DW-1] ? DW'(-i_dl) : DW'(i_dl);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ln   <= (DW+30)'(mag) * (DW+30)'(pcrt_pkg::LN2_Q30);
            r_neg1 <= i_dl[DW-1];
            r_yq   <= i_yq;
        end
    end

    // round half up on the magnitude
    assign ln_rnd = (DW+31)'(r_ln) + (DW+31)'(64'd1 << 29);
    assign lnm    = ln_rnd[DW+29:30];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pl   <= PW'(r_yq[HW-1:0]) * PW'(lnm);
            r_ph   <= PW'(r_yq[2*HW-1:HW]) * PW'(lnm);
            r_neg2 <= r_neg1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= (FW'(r_ph) << HW) + FW'(r_pl);
            r_neg3 <= r_neg2;
        end
    end

    assign mag64 = (r_prod[FW-1:79] != '0) ? pcrt_pkg::S64_MAX
                                            : $signed({1'b0, r_prod[78:16]});

    always_ff @(posedge i_clk) begin
        if (i_en) r_val <= r_neg3 ? -mag64 : mag64;
    end

    assign o_val = r_val;

endmodule

@@ src/poisson_coverage_ratio_test_unit.sv @@
// Poisson coverage ratio test. Words enter on the input channel (i_in_valid /
// o_in_ready, payload i_in_data) and leave on the output channel (o_out_valid /
// i_out_ready, payload o_out_data) as the log-likelihood ratio of the fit with
// the coverage ratio inside (1-eps, 1+eps) against the fit outside it, plus a
// status bit for a zero second coverage.
// Throughput is one word per clock while the skid register is empty. The
// pipeline depth is set mainly by the 14-stage expected-count divider (four
// quotient bits per stage), then four stages of likelihood term.
// The configuration port (i_cfg_we, i_cfg_index, i_cfg_data) writes read
// length (index 0) and ratio tolerance (index 1); write it only while idle.
// Reset (synchronous, active low) empties the pipeline and loads read length
// 100 and tolerance 3277. When the receiver stalls, the held result waits in
// the output register, one more word drops into a skid register, and only then
// does o_in_ready fall and the whole pipeline hold without losing anything.
// depends on pcrt_pkg, pcrt_delay, pcrt_log2, pcrt_div, pcrt_term
module poisson_coverage_ratio_test_unit #(
    parameter int LOG_TABLE_BITS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  pcrt_pkg::t_in                      i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output pcrt_pkg::t_out                     o_out_data,
    input  logic                               i_cfg_we,
    input  logic [pcrt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pcrt_pkg::RL_W-1:0]          i_cfg_data
);

    localparam int DL_DLY   = 2 + pcrt_pkg::DIV_LAT - (3 + pcrt_pkg::LOG_LAT + 1);
    localparam int FLAG_DLY = 2 + pcrt_pkg::DIV_LAT + pcrt_pkg::TERM_LAT - 3;
    localparam int DW       = pcrt_pkg::DL_W;
    localparam int Q_W_L    = pcrt_pkg::Q_W;

    typedef struct packed {
        logic v;
        logic zcb;
        logic in_band;
        logic out_band;
        logic a_on;
        logic b_on;
        logic off;
    } t_flags;

    logic [pcrt_pkg::RL_W-1:0]  r_rl;
    logic [pcrt_pkg::TOL_W-1:0] r_tol;
    logic en, accept, push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rl  <= pcrt_pkg::RL_RESET;
            r_tol <= pcrt_pkg::TOL_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pcrt_pkg::CFG_READ_LENGTH: r_rl  <= i_cfg_data;
                pcrt_pkg::CFG_RATIO_TOL:   r_tol <= i_cfg_data[pcrt_pkg::TOL_W-1:0];
            endcase
        end
    end

    // ---- stage 1: capture
    logic r_s1_v;
    logic [pcrt_pkg::CA_W-1:0]  r_s1_ca, r_s1_cb;
    logic [pcrt_pkg::LEN_W-1:0] r_s1_la, r_s1_lb;
    logic [pcrt_pkg::K_W-1:0]   r_s1_klo, r_s1_khi;
    logic [pcrt_pkg::RL_W-1:0]  r_s1_rl;

    assign accept = i_in_valid && en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s1_v <= 1'b0;
        else if (en)  r_s1_v <= accept;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_ca  <= i_in_data.coverage_a;
            r_s1_cb  <= i_in_data.coverage_b;
            r_s1_la  <= i_in_data.length_a;
            r_s1_lb  <= i_in_data.length_b;
            r_s1_rl  <= (r_rl == '0) ? pcrt_pkg::RL_W'(1) : r_rl;
            r_s1_klo <= pcrt_pkg::ONE_Q16 - pcrt_pkg::K_W'(r_tol);
            r_s1_khi <= pcrt_pkg::ONE_Q16 + pcrt_pkg::K_W'(r_tol);
        end
    end

    // ---- stage 2: products
    logic r_s2_v;
    logic [pcrt_pkg::PROD_W-1:0] r_s2_pa, r_s2_pb;
    logic [Q_W_L-1:0] r_s2_qlo, r_s2_qhi;
    logic [pcrt_pkg::CMP_W-1:0] r_s2_lob, r_s2_hib;
    logic [pcrt_pkg::CA_W-1:0]  r_s2_ca, r_s2_cb;
    logic [pcrt_pkg::LEN_W-1:0] r_s2_la, r_s2_lb;
    logic [pcrt_pkg::K_W-1:0]   r_s2_klo, r_s2_khi;
    logic [pcrt_pkg::RL_W-1:0]  r_s2_rl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s2_v <= 1'b0;
        else if (en)  r_s2_v <= r_s1_v;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_pa  <= pcrt_pkg::PROD_W'(r_s1_ca) * pcrt_pkg::PROD_W'(r_s1_la);
            r_s2_pb  <= pcrt_pkg::PROD_W'(r_s1_cb) * pcrt_pkg::PROD_W'(r_s1_lb);
            r_s2_qlo <= Q_W_L'(r_s1_klo) * Q_W_L'(r_s1_la);
            r_s2_qhi <= Q_W_L'(r_s1_khi) * Q_W_L'(r_s1_la);
            r_s2_lob <= pcrt_pkg::CMP_W'(r_s1_klo) * pcrt_pkg::CMP_W'(r_s1_cb);
            r_s2_hib <= pcrt_pkg::CMP_W'(r_s1_khi) * pcrt_pkg::CMP_W'(r_s1_cb);
            r_s2_ca  <= r_s1_ca;
            r_s2_cb  <= r_s1_cb;
            r_s2_la  <= r_s1_la;
            r_s2_lb  <= r_s1_lb;
            r_s2_klo <= r_s1_klo;
            r_s2_khi <= r_s1_khi;
            r_s2_rl  <= r_s1_rl;
        end
    end

    // ---- stage 3: pooled sums and interval compare
    logic [pcrt_pkg::P_W-1:0]   r_s3_p;
    logic [Q_W_L-1:0]           r_s3_qlo, r_s3_qhi;
    logic [pcrt_pkg::CA_W-1:0]  r_s3_ca, r_s3_cb;
    logic [pcrt_pkg::K_W-1:0]   r_s3_klo, r_s3_khi;
    logic [pcrt_pkg::CMP_W-1:0] num;
    t_flags r_s3_fl, fl20;

    assign num = pcrt_pkg::CMP_W'({r_s2_ca, 16'h0000});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s3_fl.v <= 1'b0;
        else if (en)  r_s3_fl.v <= r_s2_v;
        if (en) begin
            r_s3_p   <= pcrt_pkg::P_W'(r_s2_pa) + pcrt_pkg::P_W'(r_s2_pb);
            r_s3_qlo <= r_s2_qlo + (Q_W_L'(r_s2_lb) << 16);
            r_s3_qhi <= r_s2_qhi + (Q_W_L'(r_s2_lb) << 16);
            r_s3_ca  <= r_s2_ca;
            r_s3_cb  <= r_s2_cb;
            r_s3_klo <= r_s2_klo;
            r_s3_khi <= r_s2_khi;
            r_s3_fl.zcb      <= (r_s2_cb == '0);
            r_s3_fl.in_band  <= (num > r_s2_lob) && (num < r_s2_hib);
            r_s3_fl.out_band <= (num < r_s2_lob) || (num > r_s2_hib);
            r_s3_fl.a_on     <= (r_s2_ca != '0) && (r_s2_la != '0);
            r_s3_fl.b_on     <= (r_s2_lb != '0);
            // zero pooled coverage or zero pooled length: that fit scores 0
            r_s3_fl.off      <= ((r_s2_pa == '0) && (r_s2_pb == '0))
                                || ((r_s2_la == '0) && (r_s2_lb == '0));
        end
    end

    // ---- expected counts
    logic [pcrt_pkg::PROD_W-1:0] yq_a, yq_b;

    pcrt_div u_div_a (.i_clk(i_clk), .i_en(en), .i_num(r_s2_pa), .i_den(r_s2_rl), .o_quo(yq_a));
    pcrt_div u_div_b (.i_clk(i_clk), .i_en(en), .i_num(r_s2_pb), .i_den(r_s2_rl), .o_quo(yq_b));

    // ---- logs
    logic [pcrt_pkg::LG_W-1:0] lg_p, lg_qlo, lg_qhi, lg_klo, lg_khi, lg_ca, lg_cb;

    pcrt_log2 #(.W(pcrt_pkg::P_W), .TB(LOG_TABLE_BITS)) u_lg_p
        (.i_clk(i_clk), .i_en(en), .i_x(r_s3_p), .o_lg(lg_p));
    pcrt_log2 #(.W(Q_W_L), .TB(LOG_TABLE_BITS)) u_lg_qlo
        (.i_clk(i_clk), .i_en(en), .i_x(r_s3_qlo), .o_lg(lg_qlo));
    pcrt_log2 #(.W(Q_W_L), .TB(LOG_TABLE_BITS)) u_lg_qhi
        (.i_clk(i_clk), .i_en(en), .i_x(r_s3_qhi), .o_lg(lg_qhi));
    pcrt_log2 #(.W(pcrt_pkg::K_W), .TB(LOG_TABLE_BITS)) u_lg_klo
        (.i_clk(i_clk), .i_en(en), .i_x(r_s3_klo), .o_lg(lg_klo));
    pcrt_log2 #(.W(pcrt_pkg::K_W), .TB(LOG_TABLE_BITS)) u_lg_khi
        (.i_clk(i_clk), .i_en(en), .i_x(r_s3_khi), .o_lg(lg_khi));
    pcrt_log2 #(.W(pcrt_pkg::CA_W), .TB(LOG_TABLE_BITS)) u_lg_ca
        (.i_clk(i_clk), .i_en(en), .i_x(r_s3_ca), .o_lg(lg_ca));
    pcrt_log2 #(.W(pcrt_pkg::CA_W), .TB(LOG_TABLE_BITS)) u_lg_cb
        (.i_clk(i_clk), .i_en(en), .i_x(r_s3_cb), .o_lg(lg_cb));

    // ---- stage 8: log2 differences per term
    logic signed [DW-1:0] r_dal, r_dbl, r_dah, r_dbh;
    logic signed [DW-1:0] dal, dbl, dah, dbh;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dal <= DW'(lg_p) - DW'(lg_qlo) + DW'(lg_klo) - DW'(lg_ca);
            r_dbl <= DW'(lg_p) - DW'(lg_qlo) + DW'(32'd16 << 16) - DW'(lg_cb);
            r_dah <= DW'(lg_p) - DW'(lg_qhi) + DW'(lg_khi) - DW'(lg_ca);
            r_dbh <= DW'(lg_p) - DW'(lg_qhi) + DW'(32'd16 << 16) - DW'(lg_cb);
        end
    end

    pcrt_delay #(.W(4*DW), .D(DL_DLY)) u_dl_dly (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_d({r_dal, r_dbl, r_dah, r_dbh}),
        .o_q({dal, dbl, dah, dbh})
    );

    pcrt_delay #(.W($bits(t_flags)), .D(FLAG_DLY)) u_fl_dly (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_d(r_s3_fl), .o_q(fl20)
    );

    // ---- terms
    logic signed [63:0] t_al, t_bl, t_ah, t_bh;

    pcrt_term u_t_al (.i_clk(i_clk), .i_en(en), .i_yq(yq_a), .i_dl(dal), .o_val(t_al));
    pcrt_term u_t_bl (.i_clk(i_clk), .i_en(en), .i_yq(yq_b), .i_dl(dbl), .o_val(t_bl));
    pcrt_term u_t_ah (.i_clk(i_clk), .i_en(en), .i_yq(yq_a), .i_dl(dah), .o_val(t_ah));
    pcrt_term u_t_bh (.i_clk(i_clk), .i_en(en), .i_yq(yq_b), .i_dl(dbh), .o_val(t_bh));

    // ---- stage 21: boundary fit totals
    logic signed [63:0] r_s21_lo, r_s21_hi;
    logic signed [63:0] ga_l, gb_l, ga_h, gb_h;
    t_flags r_s21_fl;

    assign ga_l = fl20.a_on ? t_al : '0;
    assign gb_l = fl20.b_on ? t_bl : '0;
    assign ga_h = fl20.a_on ? t_ah : '0;
    assign gb_h = fl20.b_on ? t_bh : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s21_fl.v <= 1'b0;
        else if (en)  r_s21_fl.v <= fl20.v;
        if (en) begin
            r_s21_lo <= fl20.off ? '0 : pcrt_pkg::sat_add(ga_l, gb_l);
            r_s21_hi <= fl20.off ? '0 : pcrt_pkg::sat_add(ga_h, gb_h);
            r_s21_fl.zcb      <= fl20.zcb;
            r_s21_fl.in_band  <= fl20.in_band;
            r_s21_fl.out_band <= fl20.out_band;
            r_s21_fl.a_on     <= fl20.a_on;
            r_s21_fl.b_on     <= fl20.b_on;
            r_s21_fl.off      <= fl20.off;
        end
    end

    // ---- stage 22: choose fits and difference
    logic signed [63:0] best, fit_in, fit_out;
    logic r_s22_v;
    pcrt_pkg::t_out r_s22_d;

    assign best    = (r_s21_lo > r_s21_hi) ? r_s21_lo : r_s21_hi;
    assign fit_in  = r_s21_fl.in_band  ? '0 : best;
    assign fit_out = r_s21_fl.out_band ? '0 : best;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s22_v <= 1'b0;
        else if (en)  r_s22_v <= r_s21_fl.v;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s22_d.log_ratio <= r_s21_fl.zcb ? '0 : pcrt_pkg::sat_sub(fit_in, fit_out);
            r_s22_d.status    <= r_s21_fl.zcb;
        end
    end

    // ---- output register with skid
    logic r_ov, r_skv;
    pcrt_pkg::t_out r_od, r_skd;

    assign en   = !r_skv;
    assign push = en && r_s22_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_skv <= 1'b0;
        end else if (!r_ov || i_out_ready) begin
            if (r_skv) begin
                r_ov  <= 1'b1;
                r_skv <= 1'b0;
            end else begin
                r_ov <= push;
            end
        end else if (push) begin
            r_skv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || i_out_ready) begin
            if (r_skv) r_od <= r_skd;
            else if (push) r_od <= r_s22_d;
        end else if (push) begin
            r_skd <= r_s22_d;
        end
    end

    assign o_in_ready  = en;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_od;

endmodule

@@ dv/tb_top.sv @@
// self-checking testbench for poisson_coverage_ratio_test_unit
// predicts each result in place, checks it against the output channel
// depends on pcrt_pkg and the unit's rtl only
module tb_top;

    localparam int TB = 8;
    localparam int PIPE_LAT = 22;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    pcrt_pkg::t_in        i_in_data;
    logic                 o_out_valid;
    logic                 i_out_ready;
    pcrt_pkg::t_out       o_out_data;
    logic                 i_cfg_we;
    logic [pcrt_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [pcrt_pkg::RL_W-1:0]      i_cfg_data;

    poisson_coverage_ratio_test_unit #(.LOG_TABLE_BITS(TB)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // model copy of the registers
    logic [pcrt_pkg::RL_W-1:0]  read_len;
    logic [pcrt_pkg::TOL_W-1:0] tolerance;
    int unsigned      log2_rom [0:(1<<TB)];
    pcrt_pkg::t_out   pending_ratios [$];
    int               err_count;
    int               words_sent;
    int               words_checked;
    int               status_seen;
    int               burst_left;
    bit               long_hold;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ---------------- predictor ----------------
    function automatic longint lg2_fix(input logic [63:0] x);
        int          n;
        logic [63:0] m;
        int unsigned idx;
        logic [63:0] r;
        logic [63:0] fr;
        if (x == 0) begin
            return 0;
        end
        n = 63;
        while (!x[n]) n--;
        m   = x << (63 - n);
        idx = 32'(m[62 -: TB]);
        r   = 64'(m[62-TB -: 16]);
        fr  = 64'(log2_rom[idx]);
        if (log2_rom[idx+1] > log2_rom[idx]) begin
            fr = fr + (((log2_rom[idx+1] - log2_rom[idx]) * r) >> 16);
        end
        return longint'(n) * 65536 + longint'(fr);
    endfunction

    function automatic longint clip_add(input longint a, input longint b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return pcrt_pkg::S64_MAX;
        if (s < -65'sh0_8000_0000_0000_0000) return pcrt_pkg::S64_MIN;
        return s[63:0];
    endfunction

    // expected count times a log2 difference converted to a natural log
    function automatic longint ll_term(input logic [63:0] yq, input longint dl);
        logic [63:0]  mag;
        logic [63:0]  ln_mag;
        logic [127:0] prod;
        longint       v;
        mag    = dl < 0 ? 64'(-dl) : 64'(dl);
        ln_mag = (mag * 64'(pcrt_pkg::LN2_Q30) + (64'd1 << 29)) >> 30;
        prod   = (128'(yq) * 128'(ln_mag)) >> 16;
        v      = prod > 128'h7FFF_FFFF_FFFF_FFFF ? pcrt_pkg::S64_MAX
                                                 : longint'(prod[63:0]);
        return dl < 0 ? -v : v;
    endfunction

    function automatic longint edge_fit(input logic [63:0] ca, input logic [63:0] cb,
                                        input logic [63:0] la, input logic [63:0] lb,
                                        input logic [63:0] k, input logic [63:0] rl);
        logic [63:0] p;
        logic [63:0] q;
        longint      g;
        longint      total;
        p = ca * la + cb * lb;
        q = k * la + 64'd65536 * lb;
        total = 0;
        if (p == 0 || q == 0) begin
            return 0;
        end
        g = lg2_fix(p) - lg2_fix(q);
        if (ca != 0 && la != 0) begin
            total = clip_add(total, ll_term(ca * la / rl, g + lg2_fix(k) - lg2_fix(ca)));
        end
        if (lb != 0) begin
            total = clip_add(total, ll_term(cb * lb / rl, g + 16 * 65536 - lg2_fix(cb)));
        end
        return total;
    endfunction

    function automatic pcrt_pkg::t_out predict_ratio(input pcrt_pkg::t_in w);
        pcrt_pkg::t_out res;
        logic [63:0] ca, cb, la, lb, rl, klo, khi, num;
        longint      dlo, dhi, best, fit_in, fit_out;
        bit          in_band, out_band;
        ca  = 64'(w.coverage_a);
        cb  = 64'(w.coverage_b);
        la  = 64'(w.length_a);
        lb  = 64'(w.length_b);
        rl  = read_len == 0 ? 64'd1 : 64'(read_len);
        klo = 64'd65536 - 64'(tolerance);
        khi = 64'd65536 + 64'(tolerance);
        res = '0;
        if (cb == 0) begin
            res.status = 1'b1;
            return res;
        end
        num      = ca * 64'd65536;
        in_band  = num > klo * cb && num < khi * cb;
        out_band = num < klo * cb || num > khi * cb;
        dlo      = edge_fit(ca, cb, la, lb, klo, rl);
        dhi      = edge_fit(ca, cb, la, lb, khi, rl);
        best     = dlo > dhi ? dlo : dhi;
        fit_in   = in_band ? 0 : best;
        fit_out  = out_band ? 0 : best;
        res.log_ratio = pcrt_pkg::sat_sub(fit_in, fit_out);
        return res;
    endfunction

    // ---------------- drivers ----------------
    task automatic send_word(input pcrt_pkg::t_in w);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        pending_ratios.push_back(predict_ratio(w));
        words_sent++;
    endtask

    task automatic go_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    // wait for the pipe to empty before touching the registers
    task automatic drain();
        go_idle();
        while (pending_ratios.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [pcrt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pcrt_pkg::RL_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == pcrt_pkg::CFG_READ_LENGTH) read_len = val;
        else tolerance = val[pcrt_pkg::TOL_W-1:0];
    endtask

    function automatic pcrt_pkg::t_in make_word(input logic [31:0] ca, input logic [31:0] cb,
                                                input logic [23:0] la, input logic [23:0] lb);
        pcrt_pkg::t_in w;
        w.coverage_a = ca;
        w.coverage_b = cb;
        w.length_a   = la;
        w.length_b   = lb;
        return w;
    endfunction

    // mostly ratios near the interval, then noise
    function automatic pcrt_pkg::t_in rand_word();
        logic [31:0] cb;
        logic [63:0] ca;
        logic [23:0] la, lb;
        int          d;
        int          mode;
        mode = $urandom_range(0, 9);
        cb = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 32'h00FF_FFFF) : $urandom;
        d  = $urandom_range(0, 2 * tolerance + 64) - tolerance - 32;
        if ($urandom_range(0, 3) == 0) d = $urandom_range(0, 1) ? tolerance : -tolerance;
        ca = (64'(cb) * 64'(65536 + d)) >> 16;
        if (ca > 64'hFFFF_FFFF) ca = 64'hFFFF_FFFF;
        la = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(1, 4096));
        lb = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(1, 4096));
        if (mode >= 7) return make_word($urandom, $urandom, 24'($urandom), 24'($urandom));
        if (mode == 6) return make_word($urandom, 32'($urandom_range(0, 1)), la, lb);
        return make_word(ca[31:0], cb, la, lb);
    endfunction

    // ---------------- receiver and checker ----------------
    initial begin
        int mode_left;
        int mode;
        int hold;
        i_out_ready = 1'b0;
        mode_left   = 0;
        mode        = 0;
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                i_out_ready <= 1'b0;
                for (hold = 0; hold < 300; hold++) @(negedge i_clk);
                long_hold = 1'b0;
            end
            if (mode_left == 0) begin
                mode_left = $urandom_range(10, 120);
                mode      = $urandom_range(0, 3);
            end
            mode_left--;
            case (mode)
                0: begin
                    i_out_ready <= 1'b1;
                end
                1: begin
                    i_out_ready <= 1'($urandom_range(0, 1));
                end
                2: begin
                    i_out_ready <= ($urandom_range(0, 7) == 0);
                end
                default: begin
                    i_out_ready <= ($urandom_range(0, 7) != 0);
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        pcrt_pkg::t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_ratios.size() == 0) begin
                $error("unexpected word: log_ratio %0d status %0b",
                       o_out_data.log_ratio, o_out_data.status);
                err_count++;
            end else begin
                want = pending_ratios.pop_front();
                words_checked++;
                if (want.status) status_seen++;
                if (o_out_data.log_ratio !== want.log_ratio) begin
                    $error("log_ratio: expected %0d got %0d",
                           want.log_ratio, o_out_data.log_ratio);
                    err_count++;
                end
                if (o_out_data.status !== want.status) begin
                    $error("status: expected %0b got %0b", want.status, o_out_data.status);
                    err_count++;
                end
            end
        end
    end

    // ---------------- tests ----------------
    task automatic test_directed();
        logic [31:0] klo, khi;
        klo = 32'(65536 - tolerance);
        khi = 32'(65536 + tolerance);
        send_word(make_word(32'd5, 32'd0, 24'd1, 24'd1));
        send_word(make_word(32'hFFFF_FFFF, 32'd0, 24'hFF_FFFF, 24'hFF_FFFF));
        send_word(make_word(32'd0, 32'd65536, 24'd100, 24'd100));
        send_word(make_word(32'd65536, 32'd65536, 24'd1000, 24'd1000));
        send_word(make_word(klo, 32'd65536, 24'd500, 24'd700));
        send_word(make_word(khi, 32'd65536, 24'd500, 24'd700));
        send_word(make_word(32'd131072, 32'd65536, 24'd500, 24'd700));
        send_word(make_word(32'd32768, 32'd65536, 24'd500, 24'd700));
        send_word(make_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF));
        send_word(make_word(32'hFFFF_FFFF, 32'd1, 24'hFF_FFFF, 24'hFF_FFFF));
        send_word(make_word(32'd1, 32'hFFFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF));
        send_word(make_word(32'd1, 32'd1, 24'd1, 24'd1));
        send_word(make_word(32'd70000, 32'd65536, 24'd0, 24'd300));
        send_word(make_word(32'd70000, 32'd65536, 24'd300, 24'd0));
        send_word(make_word(32'd70000, 32'd65536, 24'd0, 24'd0));
        send_word(make_word(32'd0, 32'd65536, 24'd0, 24'd50));
        send_word(make_word(32'h8000_0000, 32'h0000_8000, 24'h80_0000, 24'h00_0001));
    endtask

    task automatic test_random(input int n);
        int i;
        for (i = 0; i < n; i++) send_word(rand_word());
    endtask

    task automatic test_config_extremes();
        drain();
        write_reg(pcrt_pkg::CFG_READ_LENGTH, 16'd1);
        write_reg(pcrt_pkg::CFG_RATIO_TOL, 16'd1);
        test_directed();
        test_random(150);
        drain();
        write_reg(pcrt_pkg::CFG_READ_LENGTH, 16'hFFFF);
        write_reg(pcrt_pkg::CFG_RATIO_TOL, 16'h7FFF);
        test_directed();
        test_random(150);
        drain();
        // zero read length counts as one, zero tolerance empties the inside interval
        write_reg(pcrt_pkg::CFG_READ_LENGTH, 16'd0);
        write_reg(pcrt_pkg::CFG_RATIO_TOL, 16'd0);
        test_directed();
        test_random(100);
        drain();
    endtask

    task automatic test_backpressure();
        long_hold = 1'b1;
        test_random(80);
    endtask

    initial begin
        int ph;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = pcrt_pkg::CFG_READ_LENGTH;
        i_cfg_data  = '0;
        read_len    = pcrt_pkg::RL_RESET;
        tolerance   = pcrt_pkg::TOL_RESET;
        err_count = 0; words_sent = 0; words_checked = 0; status_seen = 0;
        burst_left = 0; long_hold = 1'b0;
        for (int i = 0; i < (1 << TB); i++) begin
            logic [63:0] acc;
            int unsigned bits;
            acc  = (64'd1 << 30) + (64'(i) << (30 - TB));
            bits = 0;
            for (int k = 15; k >= 0; k--) begin
                acc = (acc * acc) >> 30;
                if (acc[31]) begin
                    acc  = acc >> 1;
                    bits = bits | (1 << k);
                end
            end
            log2_rom[i] = bits;
        end
        log2_rom[1 << TB] = 65536;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random(300);
        test_backpressure();
        test_config_extremes();
        for (ph = 0; ph < 3; ph++) begin
            write_reg(pcrt_pkg::CFG_READ_LENGTH, 16'($urandom_range(1, 65535)));
            write_reg(pcrt_pkg::CFG_RATIO_TOL, 16'($urandom_range(1, 32767)));
            test_random(190);
            drain();
        end
        drain();
        $display("sent %0d words, checked %0d results (%0d with zero second coverage)",
                 words_sent, words_checked, status_seen);
        $display("covered reset, extreme and random register settings with a long output stall");
        if (err_count == 0 && pending_ratios.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
